// ----- rtl/cbc_pkg.sv -----
`default_nettype none

package cbc_pkg;

   // Fixed bank geometry
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_OFF_W      = 13;
   localparam int unsigned ROM_OFF_W      = 14;

   // Field widths
   localparam int unsigned ADDR_W     = 15;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned ROM_ADDR_W = 23;
   localparam int unsigned ROM_BANK_W = 9;
   localparam int unsigned RAM_BANK_W = 4;
   localparam int unsigned ROM_CODE_W = 4;
   localparam int unsigned RAM_CODE_W = 2;

   // Bus access kinds
   typedef enum logic [1:0] {
      CMD_REG_WR = 2'd0,
      CMD_ROM_RD = 2'd1,
      CMD_RAM_RD = 2'd2,
      CMD_RAM_WR = 2'd3
   } cmd_type;

   // Configuration register indexes
   localparam logic CSR_ROM_SIZE = 1'b0;
   localparam logic CSR_RAM_SIZE = 1'b1;

   // Size codes with special meaning
   localparam logic [ROM_CODE_W-1:0] ROM_CODE_8MB  = 4'd8;
   localparam logic [RAM_CODE_W-1:0] RAM_CODE_NONE = 2'd0;
   localparam logic [RAM_CODE_W-1:0] RAM_CODE_32K  = 2'd2;
   localparam logic [RAM_CODE_W-1:0] RAM_CODE_128K = 2'd3;

   localparam logic [3:0]        RAM_EN_KEY = 4'hA;
   localparam logic [DATA_W-1:0] OPEN_BUS   = 8'hFF;

endpackage

`default_nettype wire

// ----- rtl/cartridge_bank_controller.sv -----
`default_nettype none

// Cartridge bank controller: one CPU bus access per req transaction (tuser holds the
// access kind), one rsp transaction per access in the same order. A new access may
// be accepted every cycle while the result stream is not stalled; each result passes
// through the registered read of the banked RAM and then the output register.
// Bank registers are updated at the acceptance edge, so an access sees every earlier
// access. RAM bytes never written read back as undefined; RAM reads give 0xFF when the
// RAM is disabled or sized as absent. Configuration writes are taken at any time but
// belong only to idle periods.
module cartridge_bank_controller #(
   parameter int unsigned RAM_BANKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [14:0] addr, [22:15] write_data, [23] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [22:0] rom_address, [30:23] read_data, [31] zero
   output logic             rsp_tuser,   // [0] rom_valid
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_data
);

   localparam int unsigned RAM_DEPTH  = RAM_BANKS * cbc_pkg::RAM_BANK_BYTES;
   localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);
   localparam int unsigned BANK_SEL_W = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
   localparam int unsigned BANK_CODES = 1 << cbc_pkg::RAM_BANK_W;

   // Configuration registers
   logic [cbc_pkg::ROM_CODE_W-1:0] rom_code_ff, rom_code_in;
   logic [cbc_pkg::RAM_CODE_W-1:0] ram_code_ff, ram_code_in;

   // Bank state
   logic                           ram_enable_ff, ram_enable_in;
   logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [cbc_pkg::RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;

   // Stage 1: after acceptance, RAM read in flight
   logic                           s1_valid_ff, s1_valid_in;
   logic [cbc_pkg::ROM_ADDR_W-1:0] s1_rom_addr_ff;
   logic                           s1_rom_valid_ff;
   logic                           s1_ram_rd_ff;
   logic                           s1_ram_ok_ff;
   logic [cbc_pkg::DATA_W-1:0]     mem_q_ff;

   // Stage 2: output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [31:0]                    rsp_data_ff;
   logic                           rsp_user_ff;

   logic [cbc_pkg::DATA_W-1:0]     ram_mem [RAM_DEPTH];

   logic                           req_acc;
   cbc_pkg::cmd_type               cmd;
   logic [cbc_pkg::ADDR_W-1:0]     addr;
   logic [cbc_pkg::DATA_W-1:0]     wdata;
   logic                           ram_ok;
   logic [cbc_pkg::DATA_W-1:0]     low_mask;
   logic [16:0]                    mask_shift;
   logic [BANK_SEL_W-1:0]          bank_wrap [BANK_CODES];
   logic [RAM_AW-1:0]              ram_addr;
   logic [cbc_pkg::ROM_ADDR_W-1:0] rom_addr;
   logic [cbc_pkg::DATA_W-1:0]     s1_read_data;
   logic                           s1_adv;

   assign cmd   = cbc_pkg::cmd_type'(req_tuser);
   assign addr  = req_tdata[14:0];
   assign wdata = req_tdata[22:15];

   // Handshakes
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ram_ok = ram_enable_ff && (ram_code_ff != cbc_pkg::RAM_CODE_NONE);

   // Low bank mask: (2 << code) - 1, saturating at a full byte
   assign mask_shift = 17'd2 << rom_code_ff;
   assign low_mask   = 8'(mask_shift - 17'd1);

   // RAM bank wraps modulo the bank count; table worked out at elaboration
   for (genvar i = 0; i < BANK_CODES; i++) begin : g_wrap
      assign bank_wrap[i] = BANK_SEL_W'(i % RAM_BANKS);
   end

   assign ram_addr = RAM_AW'({bank_wrap[ram_bank_ff], addr[cbc_pkg::RAM_OFF_W-1:0]});

   // Bank 0 fixed below 0x4000, selected bank above
   always_comb begin
      if (addr[14]) begin
         rom_addr = {rom_bank_ff, addr[cbc_pkg::ROM_OFF_W-1:0]};
      end else begin
         rom_addr = cbc_pkg::ROM_ADDR_W'(addr);
      end
   end

   // Configuration writes
   always_comb begin
      rom_code_in = rom_code_ff;
      ram_code_in = ram_code_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cbc_pkg::CSR_ROM_SIZE: rom_code_in = csr_data;
            cbc_pkg::CSR_RAM_SIZE: ram_code_in = csr_data[1:0];
            default:               rom_code_in = rom_code_ff;
         endcase
      end
   end

   // Bank register writes, decoded by address range
   always_comb begin
      ram_enable_in = ram_enable_ff;
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      if (req_acc && cmd == cbc_pkg::CMD_REG_WR) begin
         if (addr[14:13] == 2'b00) begin
            ram_enable_in = (wdata[3:0] == cbc_pkg::RAM_EN_KEY);
         end else if (addr[14:12] == 3'b010) begin
            rom_bank_in = {rom_bank_ff[8], wdata & low_mask};
         end else if (addr[14:12] == 3'b011) begin
            if (rom_code_ff == cbc_pkg::ROM_CODE_8MB) begin
               rom_bank_in = {wdata[0], rom_bank_ff[7:0]};
            end
         end else if (addr[14:13] == 2'b10) begin
            case (ram_code_ff)
               cbc_pkg::RAM_CODE_32K:  ram_bank_in = {2'b00, wdata[1:0]};
               cbc_pkg::RAM_CODE_128K: ram_bank_in = wdata[3:0];
               default:                ram_bank_in = '0;
            endcase
         end
      end
   end

   // Pipeline control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_code_ff   <= '0;
         ram_code_ff   <= '0;
         ram_enable_ff <= 1'b0;
         rom_bank_ff   <= 9'd1;
         ram_bank_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rom_code_ff   <= rom_code_in;
         ram_code_ff   <= ram_code_in;
         ram_enable_ff <= ram_enable_in;
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_rom_valid_ff <= (cmd == cbc_pkg::CMD_ROM_RD);
         s1_rom_addr_ff  <= (cmd == cbc_pkg::CMD_ROM_RD) ? rom_addr : '0;
         s1_ram_rd_ff    <= (cmd == cbc_pkg::CMD_RAM_RD);
         s1_ram_ok_ff    <= ram_ok;
      end
   end

   // Banked RAM: write and registered read at acceptance only
   always_ff @(posedge clock) begin
      if (req_acc && cmd == cbc_pkg::CMD_RAM_WR && ram_ok) begin
         ram_mem[ram_addr] <= wdata;
      end
      if (req_acc && cmd == cbc_pkg::CMD_RAM_RD) begin
         mem_q_ff <= ram_mem[ram_addr];
      end
   end

   // Read data: RAM byte, open bus when disabled or absent, zero for other kinds
   always_comb begin
      if (!s1_ram_rd_ff) begin
         s1_read_data = '0;
      end else if (s1_ram_ok_ff) begin
         s1_read_data = mem_q_ff;
      end else begin
         s1_read_data = cbc_pkg::OPEN_BUS;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= {1'b0, s1_read_data, s1_rom_addr_ff};
         rsp_user_ff <= s1_rom_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   a_rom_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[30:23] == '0)
      else $error("ROM read result carries read data");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[22:0] == '0)
      else $error("non-ROM result carries a ROM address");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline is full");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("stalled transaction dropped");

   a_reset_state: assert property (@(posedge clock)
      reset |=> rom_bank_ff == 9'd1 && !ram_enable_ff && ram_bank_ff == '0)
      else $error("bank state not at reset value");

endmodule

`default_nettype wire
